>>> sv/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and saturation helpers for the skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int DATA_W         = 32;
	localparam int SUM_W          = 48;
	localparam int ACC_W          = 50;
	localparam int BONE_W         = 6;
	localparam int BONE_CMP_W     = 11;
	localparam int WEIGHT_W       = 17;
	localparam int MATRIX_ENTRIES = 16;
	localparam int ENTRY_W        = 4;

	localparam logic [ENTRY_W-1:0]        LAST_IDX        = 4'd11;
	localparam logic [1:0]                COL_TRANS       = 2'd3;
	localparam logic [WEIGHT_W-1:0]       WEIGHT_ONE      = 17'd65536;
	localparam logic signed [DATA_W-1:0]  TRANSLATE_SCALE = 32'sd65536;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_APPLY = 1'b1;

	typedef struct packed {
		logic                      action;
		logic [BONE_W-1:0]         bone_index;
		logic [ENTRY_W-1:0]        matrix_element;
		logic signed [DATA_W-1:0]  matrix_value;
		logic signed [DATA_W-1:0]  vertex_x;
		logic signed [DATA_W-1:0]  vertex_y;
		logic signed [DATA_W-1:0]  vertex_z;
		logic [WEIGHT_W-1:0]       weight;
		logic                      last_influence;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
	} rsp_t;

	// position of one matrix read as it moves down the datapath
	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic [1:0] col;
	} tag_t;

	function automatic logic signed [SUM_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v[ACC_W-1:SUM_W-1] == {(ACC_W-SUM_W+1){v[ACC_W-1]}})
			r = v[SUM_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(SUM_W-1){1'b0}}};
		else
			r = {1'b0, {(SUM_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){v[SUM_W-1]}})
			r = v[DATA_W-1:0];
		else if (v[SUM_W-1])
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = {1'b0, {(DATA_W-1){1'b1}}};
		return r;
	endfunction

endpackage

>>> sv/lbs_dp.sv
// ----------------------------------------------------------------------------
// lbs_dp
// Multiply-accumulate datapath: row dot products, weighting, blended sums.
// ----------------------------------------------------------------------------
module lbs_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lbs_pkg::tag_t                         tag_s1,
	input  logic signed [lbs_pkg::DATA_W-1:0]     rd_data_s1,
	input  logic signed [lbs_pkg::DATA_W-1:0]     vx,
	input  logic signed [lbs_pkg::DATA_W-1:0]     vy,
	input  logic signed [lbs_pkg::DATA_W-1:0]     vz,
	input  logic [lbs_pkg::WEIGHT_W-1:0]          weight,
	input  logic                                  clear,
	output logic signed [lbs_pkg::SUM_W-1:0]      sum_x,
	output logic signed [lbs_pkg::SUM_W-1:0]      sum_y,
	output logic signed [lbs_pkg::SUM_W-1:0]      sum_z,
	output logic                                  busy
);

	lbs_pkg::tag_t tag_s2;
	lbs_pkg::tag_t tag_s3;
	lbs_pkg::tag_t tag_s4;

	logic signed [lbs_pkg::DATA_W-1:0]   op;
	logic signed [2*lbs_pkg::DATA_W-1:0] prod_s2;
	logic signed [lbs_pkg::SUM_W-1:0]    term;
	logic signed [lbs_pkg::ACC_W-1:0]    term_ext;
	logic signed [lbs_pkg::ACC_W-1:0]    acc_q;
	logic signed [lbs_pkg::ACC_W-1:0]    row_sum;
	logic signed [lbs_pkg::SUM_W-1:0]    row_s3;
	logic signed [lbs_pkg::SUM_W+lbs_pkg::WEIGHT_W:0] wprod;
	logic signed [lbs_pkg::ACC_W-1:0]    wrow_s4;
	logic signed [lbs_pkg::SUM_W-1:0]    sum_q [0:2];
	logic signed [lbs_pkg::ACC_W-1:0]    sum_next;

	// translation column multiplies by one in Q16.16, so floor gives m3 back
	always_comb begin
		unique case (tag_s1.col)
			2'd0:    op = vx;
			2'd1:    op = vy;
			2'd2:    op = vz;
			default: op = lbs_pkg::TRANSLATE_SCALE;
		endcase
	end

	assign term     = prod_s2[2*lbs_pkg::DATA_W-1:16];
	assign term_ext = {{(lbs_pkg::ACC_W-lbs_pkg::SUM_W){term[lbs_pkg::SUM_W-1]}}, term};
	assign row_sum  = acc_q + term_ext;
	assign wprod    = row_s3 * $signed({1'b0, weight});
	assign sum_next = {{(lbs_pkg::ACC_W-lbs_pkg::SUM_W){sum_q[tag_s4.row][lbs_pkg::SUM_W-1]}},
		sum_q[tag_s4.row]} + wrow_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2       <= tag_s1;
			tag_s3.valid <= tag_s2.valid && (tag_s2.col == lbs_pkg::COL_TRANS);
			tag_s3.row   <= tag_s2.row;
			tag_s3.col   <= tag_s2.col;
			tag_s4       <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= rd_data_s1 * op;
		if (tag_s2.valid) begin
			if (tag_s2.col == 2'd0)
				acc_q <= term_ext;
			else
				acc_q <= row_sum;
		end
		if (tag_s2.valid && (tag_s2.col == lbs_pkg::COL_TRANS))
			row_s3 <= lbs_pkg::sat48(row_sum);
		wrow_s4 <= wprod[lbs_pkg::SUM_W+lbs_pkg::WEIGHT_W:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else if (clear) begin
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			sum_q[2] <= '0;
		end else if (tag_s4.valid) begin
			sum_q[tag_s4.row] <= lbs_pkg::sat48(sum_next);
		end
	end

	assign sum_x = sum_q[0];
	assign sum_y = sum_q[1];
	assign sum_z = sum_q[2];
	assign busy  = tag_s1.valid || tag_s2.valid || tag_s3.valid || tag_s4.valid;

endmodule

>>> sv/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Vertex skinning with a stored table of 4x4 bone transforms in Q16.16.
// ----------------------------------------------------------------------------
// Input channel req (valid/stall): a load transaction writes one matrix entry
// and leaves the block idle. An apply transaction brings one bone influence;
// the block reads the twelve entries of rows 0..2 from the single-port matrix
// table, one per cycle, then lets the multiply pipeline drain; it holds the
// input through the reads and the drain, and through the emit when it is the
// last influence. Bone zero or a bone at or beyond MAX_BONES skips the reads
// and emits only with a last influence. The table read port sets the rate.
// Output channel rsp (valid/stall): one transaction per last influence with
// the blended x, y, z, saturated to 32 bits. The result sits in an output
// register; a stalled receiver holds it there, and the block waits in its
// emit step only when a new result meets a full register.
// Reset clears the sums and the control; table entries are undefined until
// loaded.
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
	parameter int MAX_BONES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lbs_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lbs_pkg::rsp_t  rsp
);

	localparam int BW     = $clog2(MAX_BONES);
	localparam int ADDR_W = BW + lbs_pkg::ENTRY_W;
	localparam int DEPTH  = MAX_BONES * lbs_pkg::MATRIX_ENTRIES;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	logic [lbs_pkg::ENTRY_W-1:0]          cnt_q;
	logic [BW-1:0]                        bone_q;
	logic                                 last_q;
	logic signed [lbs_pkg::DATA_W-1:0]    vx_q;
	logic signed [lbs_pkg::DATA_W-1:0]    vy_q;
	logic signed [lbs_pkg::DATA_W-1:0]    vz_q;
	logic [lbs_pkg::WEIGHT_W-1:0]         w_q;

	logic signed [lbs_pkg::DATA_W-1:0]    table_mem [DEPTH];
	logic signed [lbs_pkg::DATA_W-1:0]    rd_data_s1;
	lbs_pkg::tag_t                        tag_s1;

	logic                                 req_fire;
	logic [lbs_pkg::BONE_CMP_W-1:0]       bone_wide;
	logic                                 bone_ok;
	logic                                 mem_we;
	logic                                 mem_re;
	logic [ADDR_W-1:0]                    mem_addr;
	logic                                 emit_fire;
	logic                                 dp_busy;
	logic signed [lbs_pkg::SUM_W-1:0]     sum_x;
	logic signed [lbs_pkg::SUM_W-1:0]     sum_y;
	logic signed [lbs_pkg::SUM_W-1:0]     sum_z;
	logic                                 rsp_valid_q;
	lbs_pkg::rsp_t                        rsp_q;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign bone_wide = {{(lbs_pkg::BONE_CMP_W-lbs_pkg::BONE_W){1'b0}}, req.bone_index};
	assign bone_ok   = (bone_wide < lbs_pkg::BONE_CMP_W'(MAX_BONES));
	assign mem_we    = req_fire && (req.action == lbs_pkg::ACT_LOAD) && bone_ok;
	assign mem_re    = (state_q == ST_READ);
	assign mem_addr  = mem_we ? {bone_wide[BW-1:0], req.matrix_element} : {bone_q, cnt_q};
	assign emit_fire = (state_q == ST_EMIT) && (!rsp_valid_q || !rsp_stall);

	// single port: a load and the reads of an apply never share a cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			table_mem[mem_addr] <= req.matrix_value;
		if (mem_re)
			rd_data_s1 <= table_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			bone_q <= bone_wide[BW-1:0];
			last_q <= req.last_influence;
			vx_q   <= req.vertex_x;
			vy_q   <= req.vertex_y;
			vz_q   <= req.vertex_z;
			w_q    <= (req.weight > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : req.weight;
		end
		if (emit_fire) begin
			rsp_q.out_x <= lbs_pkg::sat32(sum_x);
			rsp_q.out_y <= lbs_pkg::sat32(sum_y);
			rsp_q.out_z <= lbs_pkg::sat32(sum_z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tag_s1      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			tag_s1.valid <= mem_re;
			tag_s1.row   <= cnt_q[3:2];
			tag_s1.col   <= cnt_q[1:0];

			if (emit_fire)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && (req.action == lbs_pkg::ACT_APPLY)) begin
						cnt_q <= '0;
						if (bone_ok && (req.bone_index != '0))
							state_q <= ST_READ;
						else if (req.last_influence)
							state_q <= ST_EMIT;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lbs_pkg::LAST_IDX)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// wait until the last weighted row lands in its sum
					if (!dp_busy)
						state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_fire)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	lbs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_s1     (tag_s1),
		.rd_data_s1 (rd_data_s1),
		.vx         (vx_q),
		.vy         (vy_q),
		.vz         (vz_q),
		.weight     (w_q),
		.clear      (emit_fire),
		.sum_x      (sum_x),
		.sum_y      (sum_y),
		.sum_z      (sum_z),
		.busy       (dp_busy)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> !dp_busy)
		else $error("emit while the datapath still holds work");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (cnt_q <= lbs_pkg::LAST_IDX))
		else $error("read counter past the last row entry");

	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> !mem_we)
		else $error("table write collides with a read");

endmodule
